// ===== hdl/tkims_pkg.sv =====
// Shared types and constants for the two-key index merge sorter.
package tkims_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned IdW      = 6;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned QDepth   = 2;

  // Loaded item as it travels from the loader to the sorter.
  typedef struct packed {
    logic [IdW-1:0]         item_id;
    logic signed [KeyW-1:0] primary_key;
    logic signed [KeyW-1:0] secondary_key;
    logic                   last_item;
  } item_t;

endpackage

// ===== hdl/tkims_front.sv =====
// Input stage: accepts words from the slave side and buffers them in a short queue.
module tkims_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  tkims_pkg::item_t       s_item_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output tkims_pkg::item_t       q_item_o
);
  import tkims_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  item_t           buf_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign s_ready_o = (cnt_q != QDepth[PtrW:0]);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = buf_q[rd_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= s_item_i;
  end

endmodule

// ===== hdl/tkims_back.sv =====
// Sorter: stores a batch, runs bottom-up merge passes, emits sorted identifiers.
module tkims_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  tkims_pkg::item_t       q_item_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [tkims_pkg::IdW-1:0] m_id_o,
  output logic                   m_last_o,
  output logic                   m_ovf_o,
  output logic                   busy_o
);
  import tkims_pkg::*;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_KEYS  = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_CWR   = 9'b000100000,
    S_ERD   = 9'b001000000,
    S_EID   = 9'b010000000,
    S_EOUT  = 9'b100000000
  } state_e;

  state_e state_q;

  // Memories: item data by load position, order arrays of positions
  logic [IdW-1:0]  id_mem  [MaxItems];
  logic [KeyW-1:0] pk_mem  [MaxItems];
  logic [KeyW-1:0] sk_mem  [MaxItems];
  logic [IdxW-1:0] ord_mem [MaxItems];
  logic [IdxW-1:0] scr_mem [MaxItems];

  logic [CntW-1:0] n_q;
  logic            ovf_q;
  logic [CntW:0]   width_q, mid_q, hi_q, left_q, right_q, k_q;
  logic [IdxW-1:0] pl_q, pr_q, cp_q, ep_q;
  logic [KeyW-1:0] lpk_q, lsk_q, rpk_q, rsk_q;
  logic            take_right;
  logic [CntW:0]   n_ext, mid_c, hi_c, lo_n;

  assign n_ext     = {1'b0, n_q};
  assign q_ready_o = (state_q == S_LOAD);
  assign busy_o    = (state_q != S_LOAD);

  // Compare: right wins on smaller primary, or equal primary and larger secondary
  always_comb begin
    logic right_first;
    right_first = ($signed(rpk_q) < $signed(lpk_q)) ||
                  (rpk_q == lpk_q && $signed(rsk_q) > $signed(lsk_q));
    take_right = (right_q < hi_q) && ((left_q >= mid_q) || right_first);
  end

  // Next run bounds
  always_comb begin
    lo_n  = hi_q;
    mid_c = lo_n + width_q;
    if (mid_c > n_ext) mid_c = n_ext;
    hi_c  = lo_n + (width_q << 1);
    if (hi_c > n_ext) hi_c = n_ext;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      width_q <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      left_q  <= '0;
      right_q <= '0;
      k_q     <= '0;
      m_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (q_valid_i) begin
            logic [CntW-1:0] nn;
            nn = n_q;
            if (n_q != MaxItems[CntW-1:0]) nn = n_q + 1'b1;
            else ovf_q <= 1'b1;
            n_q <= nn;
            if (q_item_i.last_item) begin
              if ({1'b0, nn} <= {{CntW{1'b0}}, 1'b1}) begin
                k_q     <= '0;
                state_q <= S_ERD;
              end else begin
                width_q <= {{CntW{1'b0}}, 1'b1};
                left_q  <= '0;
                k_q     <= '0;
                mid_q   <= {{CntW{1'b0}}, 1'b1};
                right_q <= {{CntW{1'b0}}, 1'b1};
                hi_q    <= ((CntW+1)'(2) > {1'b0, nn}) ? {1'b0, nn} : (CntW+1)'(2);
                state_q <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: state_q <= S_KEYS;
        S_KEYS:  state_q <= S_CMP;
        S_CMP: begin
          // One merged element per fetch, key read and compare
          if (take_right) right_q <= right_q + 1'b1;
          else left_q <= left_q + 1'b1;
          if (k_q + 1'b1 < hi_q) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_FETCH;
          end else if (hi_q < n_ext) begin
            left_q  <= lo_n;
            k_q     <= lo_n;
            mid_q   <= mid_c;
            right_q <= mid_c;
            hi_q    <= hi_c;
            state_q <= S_FETCH;
          end else begin
            k_q     <= '0;
            state_q <= S_COPY;
          end
        end
        S_COPY: state_q <= S_CWR;
        S_CWR: begin
          if (k_q + 1'b1 < n_ext) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_COPY;
          end else if ((width_q << 1) < n_ext) begin
            width_q <= width_q << 1;
            left_q  <= '0;
            k_q     <= '0;
            mid_q   <= ((width_q << 1) > n_ext) ? n_ext : (width_q << 1);
            right_q <= ((width_q << 1) > n_ext) ? n_ext : (width_q << 1);
            hi_q    <= ((width_q << 2) > n_ext) ? n_ext : (width_q << 2);
            state_q <= S_FETCH;
          end else begin
            k_q     <= '0;
            state_q <= S_ERD;
          end
        end
        S_ERD: begin
          if (n_q == '0) begin
            state_q <= S_LOAD;
            ovf_q   <= 1'b0;
          end else begin
            state_q <= S_EID;
          end
        end
        S_EID: begin
          m_valid_o <= 1'b1;
          state_q   <= S_EOUT;
        end
        S_EOUT: begin
          if (m_ready_i) begin
            m_valid_o <= 1'b0;
            if (k_q + 1'b1 == n_ext) begin
              n_q     <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && q_valid_i && n_q != MaxItems[CntW-1:0]) begin
      id_mem[n_q[IdxW-1:0]]  <= q_item_i.item_id;
      pk_mem[n_q[IdxW-1:0]]  <= q_item_i.primary_key;
      sk_mem[n_q[IdxW-1:0]]  <= q_item_i.secondary_key;
      ord_mem[n_q[IdxW-1:0]] <= n_q[IdxW-1:0];
    end
    if (state_q == S_FETCH) begin
      pl_q <= ord_mem[left_q[IdxW-1:0]];
      pr_q <= ord_mem[right_q[IdxW-1:0]];
    end
    if (state_q == S_KEYS) begin
      lpk_q <= pk_mem[pl_q];
      lsk_q <= sk_mem[pl_q];
      rpk_q <= pk_mem[pr_q];
      rsk_q <= sk_mem[pr_q];
    end
    if (state_q == S_CMP)
      scr_mem[k_q[IdxW-1:0]] <= take_right ? pr_q : pl_q;
    if (state_q == S_COPY)
      cp_q <= scr_mem[k_q[IdxW-1:0]];
    if (state_q == S_CWR)
      ord_mem[k_q[IdxW-1:0]] <= cp_q;
    if (state_q == S_ERD)
      ep_q <= ord_mem[k_q[IdxW-1:0]];
    if (state_q == S_EID) begin
      m_id_o   <= id_mem[ep_q];
      m_last_o <= (k_q + 1'b1 == n_ext);
      m_ovf_o  <= ovf_q;
    end
  end

endmodule

// ===== hdl/two_key_index_merge_sort.sv =====
// Top level of the two-key index merge sorter.
// Usage: stream items on the slave side (s_axis_*), one word per item;
// tdata holds item_id, primary_key, secondary_key; tlast marks the batch end.
// Up to 64 items are kept; later items are dropped and the batch's results
// all carry the overflow flag (tuser bit 0 on the master side).
// Loading takes one word per cycle. After tlast the sorter runs ceil(log2(n))
// merge passes: position fetch, key read and compare per merged element,
// then a read and a write per element to copy the order back, as separate
// steps because the order, key and scratch memories have registered reads.
// Results then leave one word at a time (order read, identifier read,
// handshake), sorted_id in tdata, tlast on the final one.
// The sorter takes one batch at a time.
// A two-word queue decouples the input from the sorter; while sorting, the
// slave side fills that queue and then deasserts tready.
// Reset clears the queue, the counters and the state; stored data is kept.
// When the receiver stalls, the current result holds on the master side.
module two_key_index_merge_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [5:0] item_id, [37:6] primary_key,
                                     // [69:38] secondary_key, zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [5:0] sorted_id, zero pad
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser   // [0] overflowed
);
  import tkims_pkg::*;

  item_t          in_item, q_item;
  logic           q_valid, q_ready, busy;
  logic [IdW-1:0] id;

  assign in_item.item_id       = s_axis_tdata[5:0];
  assign in_item.primary_key   = s_axis_tdata[37:6];
  assign in_item.secondary_key = s_axis_tdata[69:38];
  assign in_item.last_item     = s_axis_tlast;

  tkims_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_item_i(in_item),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  tkims_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_id_o(id), .m_last_o(m_axis_tlast), .m_ovf_o(m_axis_tuser[0]),
    .busy_o(busy)
  );

  assign m_axis_tdata = {2'b00, id};

`ifndef NO_ASSERTIONS
  // No output word while the sorter is loading
  a_no_out_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !m_axis_tvalid) else $error("output valid while loading");
  // The queue is not drained while the sorter is busy
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_ready) else $error("queue popped while busy");
  // After a final word is taken, the sorter returns to loading
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !busy)
    else $error("batch did not end after last word");
`endif

endmodule
